@@ src/tad_pkg.sv @@
// shared types and constants for the twist to ackermann drive block
// no dependencies
package tad_pkg;
    localparam int ZW = 34;
    localparam int XYW = 42;
    localparam int SW = 16;
    localparam int DW = 16;
    localparam int FB = 11;
    localparam int STW = 11;
    localparam int NSTEP = 16;
    localparam int SQW = 33;
    localparam int RW = 17;
    localparam logic [19:0] STEER_SCALE = 20'd633500;
    localparam int SCALE_SH = 51 - FB;

    typedef enum logic [1:0] {
        CFG_MAX_FWD = 2'd0,
        CFG_MAX_REV = 2'd1,
        CFG_WHEELBASE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic neg_x;
        logic flip;
        logic live;
        logic [DW-1:0] ax;
        logic [DW-2:0] lim_f;
        logic [DW-2:0] lim_r;
    } t_ctl;

    function automatic logic [ZW-1:0] atan_unit(input logic [4:0] i);
        logic [ZW-1:0] r;
        begin
            case (i)
                5'd0: r = 34'd536870912;
                5'd1: r = 34'd316933406;
                5'd2: r = 34'd167458907;
                5'd3: r = 34'd85004756;
                5'd4: r = 34'd42667331;
                5'd5: r = 34'd21354465;
                5'd6: r = 34'd10679838;
                5'd7: r = 34'd5340245;
                5'd8: r = 34'd2670163;
                5'd9: r = 34'd1335087;
                5'd10: r = 34'd667544;
                5'd11: r = 34'd333772;
                5'd12: r = 34'd166886;
                5'd13: r = 34'd83443;
                5'd14: r = 34'd41722;
                5'd15: r = 34'd20861;
                5'd16: r = 34'd10430;
                5'd17: r = 34'd5215;
                5'd18: r = 34'd2608;
                5'd19: r = 34'd1304;
                5'd20: r = 34'd652;
                5'd21: r = 34'd326;
                5'd22: r = 34'd163;
                5'd23: r = 34'd81;
                5'd24: r = 34'd41;
                5'd25: r = 34'd20;
                5'd26: r = 34'd10;
                5'd27: r = 34'd5;
                5'd28: r = 34'd3;
                5'd29: r = 34'd1;
                5'd30: r = 34'd1;
                default: r = 34'd0;
            endcase
            return r;
        end
    endfunction
endpackage

@@ src/tad_cell.sv @@
// one pipeline cell: a cordic vectoring step and a restoring square root step
// depends on tad_pkg
module tad_cell import tad_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic signed [XYW-1:0] i_x,
    input  logic signed [XYW-1:0] i_y,
    input  logic signed [ZW-1:0]  i_z,
    input  logic [SQW-1:0]        i_rem,
    input  logic [RW-1:0]         i_root,
    input  logic [SQW-1:0]        i_n,
    output t_ctl                  o_ctl,
    output logic signed [XYW-1:0] o_x,
    output logic signed [XYW-1:0] o_y,
    output logic signed [ZW-1:0]  o_z,
    output logic [SQW-1:0]        o_rem,
    output logic [RW-1:0]         o_root,
    output logic [SQW-1:0]        o_n
);
    localparam int BITP = 2 * (NSTEP - 1 - STEP);
    t_ctl r_ctl;
    logic signed [XYW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [SQW-1:0] r_rem, r_n, n_rem;
    logic [RW-1:0] r_root, n_root;
    logic [SQW+1:0] trial, cur;

    always_comb begin
        if (i_y >= 0) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + $signed(atan_unit(5'(STEP)));
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - $signed(atan_unit(5'(STEP)));
        end
        cur = {i_rem, 2'(i_n >> BITP)};
        trial = {(SQW+2-RW-2)'(0), i_root, 2'b01};
        if (cur >= trial) begin
            n_rem = SQW'(cur - trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem = SQW'(cur);
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_rem <= n_rem;
            r_root <= n_root;
            r_n <= i_n;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_n = r_n;
endmodule

@@ src/twist_to_ackermann_drive.sv @@
// top level of the velocity command to ackermann drive converter
// depends on tad_pkg and tad_cell
//
// usage: input channel i_valid/o_ready carries linear_x, linear_y, angular_z;
// output channel o_valid/i_ready carries speed and steering. config channel
// i_cfg_valid/o_cfg_ready writes the forward speed limit (0), the reverse speed
// limit (1), wheelbase (2); other indexes are ignored. config is always ready.
// the datapath is a row of 16 cells, each doing one cordic step and one
// square root digit per cycle, plus a front stage (absolute values, multiplies)
// and two back stages (scale multiply, rounding and clamp).
// depth: 19 register stages from the input transfer to o_valid.
// throughput: one transfer per cycle; the whole row advances together and
// holds when the output register is full and not taken.
// reset: all stages empty, config registers take their defaults.
// stall: when the output register is full and i_ready is low, the whole row
// freezes and o_ready drops in the same cycle; it rises again with i_ready.
module twist_to_ackermann_drive import tad_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [DW-1:0]  i_linear_x,
    input  logic signed [DW-1:0]  i_linear_y,
    input  logic signed [DW-1:0]  i_angular_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [DW-1:0]  o_speed,
    output logic signed [STW-1:0] o_steering,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [DW-2:0]         i_cfg_data
);
    logic [DW-2:0] r_max_fwd, r_max_rev, r_wb;
    logic en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fwd <= 15'd4096;
            r_max_rev <= 15'd2048;
            r_wb <= 15'd666;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_FWD: r_max_fwd <= i_cfg_data;
                CFG_MAX_REV: r_max_rev <= i_cfg_data;
                CFG_WHEELBASE: r_wb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front stage
    logic [DW-1:0] ax, ay, aa;
    logic [XYW-1:0] ym, xm;
    t_ctl n_c0, r_c0;
    logic signed [XYW-1:0] r_x0, r_y0;
    logic [SQW-1:0] r_n0;

    always_comb begin
        ax = i_linear_x[DW-1] ? DW'(-i_linear_x) : DW'(i_linear_x);
        ay = i_linear_y[DW-1] ? DW'(-i_linear_y) : DW'(i_linear_y);
        aa = i_angular_z[DW-1] ? DW'(-i_angular_z) : DW'(i_angular_z);
        ym = XYW'(r_wb) * XYW'(aa);
        xm = XYW'(ax) << FB;
        n_c0.valid = i_valid;
        n_c0.neg_x = i_linear_x[DW-1];
        n_c0.flip = i_linear_x[DW-1] ^ i_angular_z[DW-1];
        n_c0.live = (i_linear_x != '0) && (i_angular_z != '0) && (r_wb != '0);
        n_c0.ax = ax;
        n_c0.lim_f = r_max_fwd;
        n_c0.lim_r = r_max_rev;
    end

    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0.valid <= 1'b0;
        end else if (en) begin
            r_c0 <= n_c0;
        end
        if (en) begin
            // both below 2^32, already under the normalize limit
            r_x0 <= $signed(xm);
            r_y0 <= $signed(ym);
            r_n0 <= SQW'(ax) * SQW'(ax) + SQW'(ay) * SQW'(ay);
        end
    end

    // cell row
    t_ctl c_ctl [0:NSTEP];
    logic signed [XYW-1:0] c_x [0:NSTEP];
    logic signed [XYW-1:0] c_y [0:NSTEP];
    logic signed [ZW-1:0] c_z [0:NSTEP];
    logic [SQW-1:0] c_rem [0:NSTEP];
    logic [RW-1:0] c_root [0:NSTEP];
    logic [SQW-1:0] c_n [0:NSTEP];

    assign c_ctl[0] = r_c0;
    assign c_x[0] = r_x0;
    assign c_y[0] = r_y0;
    assign c_z[0] = '0;
    assign c_rem[0] = '0;
    assign c_root[0] = '0;
    assign c_n[0] = r_n0;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        tad_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(c_ctl[g]), .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
            .i_rem(c_rem[g]), .i_root(c_root[g]), .i_n(c_n[g]),
            .o_ctl(c_ctl[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1]),
            .o_rem(c_rem[g+1]), .o_root(c_root[g+1]), .o_n(c_n[g+1])
        );
    end

    // scale stage
    t_ctl r_c1;
    logic [ZW+19:0] r_prod;
    logic r_zneg;
    logic [DW-1:0] r_mag;
    logic [ZW-1:0] zm;
    logic [DW-1:0] mag, cl;

    assign zm = c_z[NSTEP][ZW-1] ? ZW'(-c_z[NSTEP]) : ZW'(c_z[NSTEP]);
    assign mag = DW'(c_root[NSTEP]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
        end else if (en) begin
            r_c1 <= c_ctl[NSTEP];
        end
        if (en) begin
            r_prod <= (ZW+20)'(zm) * (ZW+20)'(STEER_SCALE);
            r_zneg <= c_z[NSTEP][ZW-1];
            r_mag <= mag;
        end
    end

    // output register
    logic r_ovalid;
    logic signed [DW-1:0] r_speed, n_speed;
    logic signed [STW-1:0] r_steer, n_steer;
    logic [ZW+19:0] rnd;

    assign en = !r_ovalid || i_ready;

    always_comb begin
        rnd = (r_prod + ((ZW+20)'(1) << (SCALE_SH - 1))) >> SCALE_SH;
        n_steer = '0;
        if (r_c1.live) begin
            n_steer = r_zneg ? -$signed(STW'(rnd)) : $signed(STW'(rnd));
            if (r_c1.flip)
                n_steer = -n_steer;
        end
        if (r_c1.neg_x) begin
            cl = (r_mag > DW'(r_c1.lim_r)) ? DW'(r_c1.lim_r) : r_mag;
            n_speed = -$signed(cl);
            if (cl != '0)
                n_steer = -n_steer;
        end else begin
            cl = (r_mag > DW'(r_c1.lim_f)) ? DW'(r_c1.lim_f) : r_mag;
            n_speed = $signed(cl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_c1.valid;
        end
        if (en) begin
            r_speed <= n_speed;
            r_steer <= n_steer;
        end
    end

    assign o_valid = r_ovalid;
    assign o_speed = r_speed;
    assign o_steering = r_steer;

    logic unused;
    assign unused = ^{c_x[NSTEP], c_y[NSTEP], c_rem[NSTEP],
                      c_n[NSTEP], c_ctl[NSTEP].ax, r_c1.ax};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_speed))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("stall without a pending result");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_c1.valid && !r_c1.live |=> o_steering == '0)
        else $error("steering not zero");
endmodule

@@ sim/tad_checker.sv @@
// watches the command and drive channels, predicts speed and steering, compares
// depends on tad_pkg and the channel signals from the testbench top
`timescale 1ns / 1ps
module tad_checker import tad_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_in_ready,
    input  logic signed [DW-1:0]  i_linear_x,
    input  logic signed [DW-1:0]  i_linear_y,
    input  logic signed [DW-1:0]  i_angular_z,
    input  logic                  i_out_valid,
    input  logic                  i_ready,
    input  logic signed [DW-1:0]  i_speed,
    input  logic signed [STW-1:0] i_steering,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [DW-2:0]         i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);
    typedef struct packed {
        logic signed [DW-1:0]  speed;
        logic signed [STW-1:0] steering;
    } t_drive;

    longint lim_fwd, lim_rev, wb;
    t_drive drive_q[$];
    longint turn_table[32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    function automatic longint int_sqrt(longint n);
        longint root, b;
        root = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    function automatic longint heading_turns(longint xm, longint ym);
        longint x, y, z, xs, ys;
        z = 0;
        while (xm >= (64'sd1 <<< 40) || ym >= (64'sd1 <<< 40)) begin
            xm = xm >>> 1;
            ym = ym >>> 1;
        end
        x = xm;
        y = ym;
        for (int i = 0; i < NSTEP; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + turn_table[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - turn_table[i];
            end
        end
        return z;
    endfunction

    function automatic t_drive drive_of(longint lx, longint ly, longint az);
        longint ax, ay, aa, mag, spd, st, z, zm, r;
        t_drive d;
        ax = lx < 0 ? -lx : lx;
        ay = ly < 0 ? -ly : ly;
        aa = az < 0 ? -az : az;
        mag = int_sqrt(ax * ax + ay * ay);
        st = 0;
        if (lx < 0) begin
            if (mag > lim_rev) mag = lim_rev;
            spd = -mag;
        end else begin
            if (mag > lim_fwd) mag = lim_fwd;
            spd = mag;
        end
        if (lx != 0 && az != 0 && wb != 0) begin
            z = heading_turns(ax <<< FB, wb * aa);
            zm = z < 0 ? -z : z;
            r = (zm * 633500 + (64'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
            st = z < 0 ? -r : r;
            if ((az < 0) != (lx < 0)) st = -st;
        end
        if (spd < 0) st = -st;
        d.speed = spd[DW-1:0];
        d.steering = st[STW-1:0];
        return d;
    endfunction

    assign o_pending = drive_q.size();

    always @(posedge i_clk) begin
        t_drive exp_d;
        if (!i_rst_n) begin
            lim_fwd <= 4096;
            lim_rev <= 2048;
            wb <= 666;
            o_errors <= 0;
            drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_FWD: lim_fwd <= i_cfg_data;
                    CFG_MAX_REV: lim_rev <= i_cfg_data;
                    CFG_WHEELBASE: wb <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                if (drive_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected drive transfer %0d %0d",
                        i_speed, i_steering);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_d = drive_q.pop_front();
                    if (exp_d.speed !== i_speed || exp_d.steering !== i_steering) begin
                        if (o_errors < 10) $display("mismatch: exp %0d %0d got %0d %0d",
                            exp_d.speed, exp_d.steering, i_speed, i_steering);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready)
                drive_q.push_back(drive_of(i_linear_x, i_linear_y, i_angular_z));
        end
    end
endmodule

@@ sim/testbench.sv @@
// drives velocity commands and register writes into the drive converter
// depends on tad_pkg, twist_to_ackermann_drive and tad_checker
`timescale 1ns / 1ps
module testbench;
    import tad_pkg::*;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [DW-1:0] i_linear_x, i_linear_y, i_angular_z, o_speed;
    logic signed [STW-1:0] o_steering;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [DW-2:0] i_cfg_data;
    int errors, pending;
    bit calm, hold_long;

    twist_to_ackermann_drive i_dut (.*);

    tad_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready),
        .i_linear_x, .i_linear_y, .i_angular_z,
        .i_out_valid(o_valid), .i_ready, .i_speed(o_speed), .i_steering(o_steering),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver stalls in bursts, with one long hold-off
    initial begin
        int n;
        i_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                i_ready <= 0;
                repeat (60) @(posedge i_clk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [DW-1:0] pick_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_cmd(logic [DW-1:0] lx, logic [DW-1:0] ly, logic [DW-1:0] az);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1;
        i_linear_x <= lx;
        i_linear_y <= ly;
        i_angular_z <= az;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DW-2:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    initial begin
        logic [DW-2:0] settings [4][3] = '{
            '{15'd4096, 15'd2048, 15'd666},
            '{15'h7fff, 15'h7fff, 15'h7fff},
            '{15'd0, 15'd0, 15'd0},
            '{15'd12000, 15'd300, 15'd2500}};
        i_rst_n = 0;
        i_valid = 0;
        i_linear_x = 0;
        i_linear_y = 0;
        i_angular_z = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        calm = 0;
        hold_long = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed corners at reset settings, then with zero reverse limit and wheelbase
        send_cmd(16'h8000, 16'h8000, 16'h8000);
        send_cmd(16'h7fff, 16'h7fff, 16'h7fff);
        send_cmd(16'h7fff, 16'h8000, 16'h8000);
        send_cmd(16'h8000, 16'h7fff, 16'h7fff);
        send_cmd(0, 16'd500, 16'd1000);
        send_cmd(16'd1000, 0, 0);
        send_cmd(-16'sd1000, 0, 16'd700);
        send_cmd(16'd1, 0, 16'h7fff);
        send_cmd(-16'sd1, 16'd3, -16'sd1);
        send_cmd(16'd2048, 16'd2048, -16'sd2048);
        send_cmd(0, 0, 0);
        send_cmd(16'hffff, 16'hffff, 16'hffff);
        drain();
        write_reg(CFG_MAX_REV, 0);
        write_reg(CFG_WHEELBASE, 0);
        send_cmd(-16'sd3000, 16'd100, 16'd900);
        send_cmd(16'd3000, 16'd100, 16'd900);
        drain();

        // long receiver hold-off while commands keep coming
        hold_long = 1;
        for (int k = 0; k < 40; k++)
            send_cmd(pick_field(), pick_field(), pick_field());
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_MAX_FWD, settings[p][0]);
            write_reg(CFG_MAX_REV, settings[p][1]);
            write_reg(CFG_WHEELBASE, settings[p][2]);
            write_reg(t_cfg_idx'(2'd3), 15'h1234);
            if (p == 3) calm = 1;
            for (int k = 0; k < 450; k++)
                send_cmd(pick_field(), pick_field(), pick_field());
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
